FILE: rtl/esf_pkg.sv
// Package: shared types and constants for the EBML segment size finder.
package esf_pkg;

	localparam int LEN_BITS = 32;
	localparam int POS_W    = LEN_BITS;
	localparam int ACC_W    = 56;
	localparam int OFF_W    = 58;
	localparam int SIZE_W   = 57;
	localparam int ID_W     = 32;

	localparam logic [ID_W-1:0] SEGMENT_ID = 32'h1853_8067;
	localparam logic [7:0] MAGIC_B0 = 8'h1A;
	localparam logic [7:0] MAGIC_B1 = 8'h45;
	localparam logic [7:0] MAGIC_B2 = 8'hDF;
	localparam logic [7:0] MAGIC_B3 = 8'hA3;
	localparam int MIN_BUFFER = 16;

	typedef enum logic [2:0] {
		PH_MAGIC = 3'd0,
		PH_HSIZE = 3'd1,
		PH_SKIP  = 3'd2,
		PH_ID    = 3'd3,
		PH_SIZE  = 3'd4
	} phase_t;

	typedef enum logic [1:0] {
		VD_REJECT    = 2'd0,
		VD_STRUCT    = 2'd1,
		VD_CONTAINER = 2'd2,
		VD_VERIFIED  = 2'd3
	} verdict_t;

	typedef struct packed {
		logic [7:0]  data;
		logic [31:0] len;
		logic        fin;
	} item_t;

	typedef struct packed {
		verdict_t          verdict;
		logic [SIZE_W-1:0] file_size;
		logic              unk;
	} result_t;

endpackage

FILE: rtl/esf_core.sv
// Parser state registers and combinational next-state logic for one byte.
module esf_core import esf_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    go,
	input  item_t   item,
	output result_t res
);

	typedef struct packed {
		phase_t            phase;
		logic [ACC_W-1:0]  acc;
		logic [3:0]        left;
		logic [3:0]        total;
		logic [ID_W-1:0]   elem_id;
		logic [OFF_W-1:0]  next_off;
		verdict_t          h_verdict;
		logic [SIZE_W-1:0] h_size;
		logic              h_unk;
		logic              decided;
		logic [POS_W-1:0]  pos;
	} st_t;

	st_t st_q, st_d;

	function automatic st_t f_reset();
		st_t s;
		s = '0;
		s.phase = PH_MAGIC;
		s.h_verdict = VD_REJECT;
		return s;
	endfunction

	function automatic st_t f_decide(st_t s, verdict_t v, logic [SIZE_W-1:0] fs, logic u);
		st_t r;
		r = s;
		r.h_verdict = v;
		r.h_size = fs;
		r.h_unk = u;
		r.decided = 1'b1;
		return r;
	endfunction

	function automatic logic [3:0] f_lead(logic [7:0] b, int maxn);
		logic [3:0] n;
		n = '0;
		for (int i = 0; i < 8; i++) begin
			if (n == '0 && b[7-i] && i < maxn)
				n = 4'(i + 1);
		end
		return n;
	endfunction

	function automatic logic [ACC_W-1:0] f_ones(logic [3:0] t);
		logic [5:0] sh;
		sh = 6'(t) * 6'd7;
		return ~({ACC_W{1'b1}} << sh);
	endfunction

	function automatic st_t f_enter_skip(st_t s, logic [POS_W-1:0] len);
		st_t r;
		r = s;
		if ((s.next_off + OFF_W'(4)) > OFF_W'(len))
			r = f_decide(s, VD_CONTAINER, '0, 1'b0);
		else
			r.phase = PH_SKIP;
		return r;
	endfunction

	function automatic st_t f_finish_id(st_t s, logic [POS_W-1:0] p, logic [POS_W-1:0] len);
		st_t r;
		r = s;
		r.elem_id = s.acc[ID_W-1:0];
		if ((POS_W'(1) + (POS_W+1)'(p)) >= (POS_W+1)'(len)) begin
			r = f_decide(r, VD_CONTAINER, '0, 1'b0);
		end else begin
			r.phase = PH_SIZE;
			r.left = '0;
		end
		return r;
	endfunction

	function automatic st_t f_finish_size(st_t s, logic [POS_W-1:0] p, logic [POS_W-1:0] len);
		st_t r;
		logic [OFF_W-1:0] e;
		logic u;
		r = s;
		e = OFF_W'(p) + OFF_W'(1) + OFF_W'(s.acc);
		u = (s.acc == f_ones(s.total));
		if (s.elem_id == SEGMENT_ID) begin
			r = f_decide(s, VD_VERIFIED,
				(!u && s.acc != '0) ? e[SIZE_W-1:0] : '0, u);
		end else if (s.acc == '0) begin
			r = f_decide(s, VD_CONTAINER, '0, 1'b0);
		end else begin
			r.next_off = e;
			r = f_enter_skip(r, len);
		end
		return r;
	endfunction

	// next state
	always_comb begin
		st_t n;
		logic [POS_W-1:0] p;
		logic [POS_W-1:0] len;
		logic [7:0] b;
		logic [3:0] ln;
		logic [7:0] mb;
		n = st_q;
		p = st_q.pos;
		len = POS_W'(item.len);
		b = item.data;
		ln = '0;
		case (p[1:0])
			2'd0:    mb = MAGIC_B0;
			2'd1:    mb = MAGIC_B1;
			2'd2:    mb = MAGIC_B2;
			default: mb = MAGIC_B3;
		endcase
		if (!st_q.decided) begin
			if (len < POS_W'(MIN_BUFFER)) begin
				n = f_decide(n, VD_REJECT, '0, 1'b0);
			end else if (p < len) begin
				case (st_q.phase)
					PH_MAGIC: begin
						if (p > POS_W'(3) || b != mb)
							n = f_decide(n, VD_REJECT, '0, 1'b0);
						else if (p == POS_W'(3))
							n.phase = PH_HSIZE;
					end
					PH_HSIZE: begin
						if (st_q.left == '0) begin
							ln = f_lead(b, 8);
							if (ln == '0) begin
								n = f_decide(n, VD_STRUCT, '0, 1'b0);
							end else begin
								n.acc = ACC_W'(b & (8'hFF >> ln));
								n.left = ln - 4'd1;
								n.total = ln;
							end
						end else begin
							n.acc = {st_q.acc[ACC_W-9:0], b};
							n.left = st_q.left - 4'd1;
						end
						if (!n.decided && n.left == '0) begin
							n.next_off = OFF_W'(p) + OFF_W'(1) + OFF_W'(n.acc);
							n = f_enter_skip(n, len);
						end
					end
					PH_SKIP: begin
						if (OFF_W'(p) == st_q.next_off) begin
							ln = f_lead(b, 4);
							if (ln == '0) begin
								n = f_decide(n, VD_CONTAINER, '0, 1'b0);
							end else begin
								n.acc = ACC_W'(b);
								n.left = ln - 4'd1;
								n.total = ln;
								n.phase = PH_ID;
								if (n.left == '0)
									n = f_finish_id(n, p, len);
							end
						end
					end
					PH_ID: begin
						n.acc = {st_q.acc[ACC_W-9:0], b};
						if (st_q.left != '0)
							n.left = st_q.left - 4'd1;
						if (n.left == '0)
							n = f_finish_id(n, p, len);
					end
					PH_SIZE: begin
						if (st_q.left == '0) begin
							ln = f_lead(b, 8);
							if (ln == '0 || ((POS_W+1)'(p) + (POS_W+1)'(ln)) > (POS_W+1)'(len)) begin
								n = f_decide(n, VD_CONTAINER, '0, 1'b0);
							end else begin
								n.acc = ACC_W'(b & (8'hFF >> ln));
								n.left = ln - 4'd1;
								n.total = ln;
							end
						end else begin
							n.acc = {st_q.acc[ACC_W-9:0], b};
							n.left = st_q.left - 4'd1;
						end
						if (!n.decided && n.left == '0)
							n = f_finish_size(n, p, len);
					end
					default: ;
				endcase
			end
		end
		if (st_q.pos != '1)
			n.pos = st_q.pos + POS_W'(1);
		if (item.fin && !n.decided) begin
			case (n.phase)
				PH_MAGIC: n = f_decide(n, VD_REJECT, '0, 1'b0);
				PH_HSIZE: n = f_decide(n, VD_STRUCT, '0, 1'b0);
				default:  n = f_decide(n, VD_CONTAINER, '0, 1'b0);
			endcase
		end
		st_d = n;
	end

	// result of a final byte
	always_comb begin
		res.verdict = st_d.h_verdict;
		res.file_size = st_d.h_size;
		res.unk = st_d.h_unk;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= f_reset();
		end else if (go) begin
			if (item.fin)
				st_q <= f_reset();
			else
				st_q <= st_d;
		end
	end

	a_clear_after_final: assert property (@(posedge clk) disable iff (!arst_n)
		go && item.fin |=> st_q.pos == '0 && !st_q.decided && st_q.phase == PH_MAGIC)
		else $error("state not cleared after final item");

	a_decided_holds: assert property (@(posedge clk) disable iff (!arst_n)
		go && !item.fin && st_q.decided |=> st_q.decided && st_q.h_verdict == $past(st_q.h_verdict))
		else $error("decision changed before final item");

	a_skip_target: assert property (@(posedge clk) disable iff (!arst_n)
		st_q.phase == PH_SKIP && !st_q.decided |-> st_q.next_off >= OFF_W'(4))
		else $error("element offset inside magic");

endmodule

FILE: rtl/ebml_segment_size_finder.sv
// Top level: input register, parse core and result register of the segment size finder.
//
//  channel | handshake         | payload
//  --------+-------------------+------------------------------------------
//  in      | in_valid/in_ready | data_byte[7:0] buffer_length[31:0] final_byte
//  out     | out_valid/out_ready | verdict[1:0] file_size[56:0] size_unknown
//
// One item per cycle is accepted while in_ready is high; each item is parsed from
// the input register. out_valid is registered and rises as the parser takes a final item.
// A final item waits in the input register only while the result register still
// holds an untaken result. arst_n clears the parser to the magic check at offset zero.
module ebml_segment_size_finder import esf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        data_byte,
	input  logic [31:0]       buffer_length,
	input  logic              final_byte,
	output logic              out_valid,
	input  logic              out_ready,
	output logic [1:0]        verdict,
	output logic [SIZE_W-1:0] file_size,
	output logic              size_unknown
);

	item_t   item_s1;
	logic    valid_s1;
	logic    go;
	result_t res;
	result_t res_q;
	logic    out_valid_q;

	assign go       = valid_s1 && (!item_s1.fin || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1.data <= data_byte;
			item_s1.len  <= buffer_length;
			item_s1.fin  <= final_byte;
		end
	end

	esf_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (go),
		.item   (item_s1),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go && item_s1.fin) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go && item_s1.fin)
			res_q <= res;
	end

	assign out_valid    = out_valid_q;
	assign verdict      = res_q.verdict;
	assign file_size    = res_q.file_size;
	assign size_unknown = res_q.unk;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		go && item_s1.fin |-> !out_valid_q || out_ready)
		else $error("result register overwritten");

	a_size_only_verified: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.verdict != VD_VERIFIED |-> res_q.file_size == '0 && !res_q.unk)
		else $error("size reported without segment");

	a_unknown_no_size: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.unk |-> res_q.file_size == '0)
		else $error("unknown size with nonzero file size");

endmodule
